// ----- rtl/core/triggered_chirp_generator_core_macros.svh -----
// assertion macros for the triggered chirp generator
`ifndef TRIGGERED_CHIRP_GENERATOR_CORE_MACROS_SVH
`define TRIGGERED_CHIRP_GENERATOR_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define TCG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("tcg assertion failed");

// next-cycle implication, disabled while reset is asserted
`define TCG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("tcg assertion failed");

`endif

// ----- rtl/core/tcg_pkg.sv -----
// shared types, constants and sine table function for the chirp generator
package tcg_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int LENGTH_BITS = 16;
  localparam int ACCEL_BITS  = 32;
  localparam int AMP_BITS    = 15;
  localparam int DATA_BITS   = 32;
  localparam int ADDR_BITS   = 4;

  localparam logic [63:0] PI_Q30     = 64'd3373259426;
  localparam logic [63:0] FULL_SCALE = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

  typedef enum logic [1:0] {
    REG_PULSE_LENGTH = 2'd0,
    REG_CHIRP_ACCEL  = 2'd1,
    REG_AMPLITUDE    = 2'd2
  } cfg_reg_e;

  // sin(pi/2 * k / 2^qlog2) scaled to full scale, q30 taylor series
  function automatic logic [SAMPLE_BITS-2:0] quarter_sine(input int unsigned k,
                                                          input int unsigned qlog2);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        val;
    int                 n;
    x    = (PI_Q30 * 64'(k)) >> (qlog2 + 1);
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    for (n = 1; n <= 8; n++) begin
      term = (term * x2) >> 30;
      case (n)
        1:       term = term / 64'd6;
        2:       term = term / 64'd20;
        3:       term = term / 64'd42;
        4:       term = term / 64'd72;
        5:       term = term / 64'd110;
        6:       term = term / 64'd156;
        7:       term = term / 64'd210;
        default: term = term / 64'd272;
      endcase
      if ((n & 1) != 0) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    val = (unsigned'(sum) * FULL_SCALE + (64'd1 << 29)) >> 30;
    if (val > FULL_SCALE) begin
      val = FULL_SCALE;
    end
    return val[SAMPLE_BITS-2:0];
  endfunction

endpackage

// ----- rtl/core/triggered_chirp_generator_core.sv -----
// Triggered linear-FM chirp generator: one input slot in, one I/Q sample out,
// one transfer per clock on each side when neither side stalls. An input
// transfer reaches its result through the address register, the sine table
// register and the amplitude multiply register, in that order. A trigger in an
// idle slot starts a pulse of pulse_length chirp samples from the next slot on;
// idle slots and the trigger slot itself give zero. Phase is a PHASE_BITS
// fraction of a cycle, quadratic in the sample count, and its top
// TABLE_ADDR_BITS bits address a quarter-wave sine table. An output stall
// fills any empty pipeline stages before the input side is stalled.
`include "triggered_chirp_generator_core_macros.svh"

module triggered_chirp_generator_core
  import tcg_pkg::*;
#(
  parameter int PHASE_BITS      = 32,
  parameter int TABLE_ADDR_BITS = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // item input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          trigger_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] out_i_o,
  output logic signed [SAMPLE_BITS-1:0] out_q_o,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_BITS-1:0]          paddr,
  input  logic [DATA_BITS-1:0]          pwdata,
  output logic [DATA_BITS-1:0]          prdata,
  output logic                          pready
);

  localparam int TA      = TABLE_ADDR_BITS;
  localparam int QUARTER = 2 ** (TA - 2);
  localparam int MAG_W   = SAMPLE_BITS - 1;
  localparam int PROD_W  = MAG_W + AMP_BITS;
  localparam logic [TA-2:0] QUARTER_IDX = (TA - 1)'(QUARTER);

  // configuration registers
  logic [LENGTH_BITS-1:0] pulse_length_q;
  logic [ACCEL_BITS-1:0]  chirp_accel_q;
  logic [AMP_BITS-1:0]    amplitude_q;
  logic                   cfg_wr;

  // sequencer state
  logic                   busy_q, busy_d;
  logic [LENGTH_BITS-1:0] idx_q, idx_d;
  logic [PHASE_BITS-1:0]  acc_q, acc_d;
  logic [PHASE_BITS-1:0]  step_q, step_d;
  logic [PHASE_BITS-1:0]  accel_ph;
  logic [LENGTH_BITS:0]   idx_next;

  // pipeline
  logic                   vld_a_q, vld_b_q, vld_c_q;
  logic                   rdy_a, rdy_b, rdy_c;
  logic                   in_acc;
  logic                   act_a_q, act_b_q;
  logic [TA-1:0]          addr_a_q;
  logic [MAG_W-1:0]       mag_s_q, mag_c_q;
  logic                   neg_s_q, neg_c_q;
  logic signed [SAMPLE_BITS-1:0] out_i_q, out_q_q;

  // table lookup signals
  logic [1:0]             quad_s, quad_c;
  logic [TA-3:0]          frac;
  logic [TA-2:0]          rom_idx_s, rom_idx_c;
  logic [MAG_W-1:0]       sine_rom [0:QUARTER];

  // multiply signals
  logic [PROD_W:0]        rnd_s, rnd_c;
  logic [SAMPLE_BITS-1:0] m_s, m_c;

  // ---------------------------------------------------------------- registers

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_length_q <= LENGTH_BITS'(1024);
      chirp_accel_q  <= '0;
      amplitude_q    <= '1;
    end else if (cfg_wr) begin
      case (cfg_reg_e'(paddr[3:2]))
        REG_PULSE_LENGTH: pulse_length_q <= pwdata[LENGTH_BITS-1:0];
        REG_CHIRP_ACCEL:  chirp_accel_q  <= pwdata[ACCEL_BITS-1:0];
        REG_AMPLITUDE:    amplitude_q    <= pwdata[AMP_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg_e'(paddr[3:2]))
      REG_PULSE_LENGTH: prdata = DATA_BITS'(pulse_length_q);
      REG_CHIRP_ACCEL:  prdata = DATA_BITS'(chirp_accel_q);
      REG_AMPLITUDE:    prdata = DATA_BITS'(amplitude_q);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- handshake

  assign rdy_c      = !vld_c_q || !out_stall_i;
  assign rdy_b      = !vld_b_q || rdy_c;
  assign rdy_a      = !vld_a_q || rdy_b;
  assign in_stall_o = !rdy_a;
  assign in_acc     = in_valid_i && rdy_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
    end else begin
      if (rdy_a) begin
        vld_a_q <= in_valid_i;
      end
      if (rdy_b) begin
        vld_b_q <= vld_a_q;
      end
      if (rdy_c) begin
        vld_c_q <= vld_b_q;
      end
    end
  end

  // ---------------------------------------------------------------- phase sequencer

  assign accel_ph = PHASE_BITS'(chirp_accel_q);
  assign idx_next = {1'b0, idx_q} + (LENGTH_BITS + 1)'(1);

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    acc_d  = acc_q;
    step_d = step_q;
    if (in_acc) begin
      if (!busy_q) begin
        if (trigger_i && pulse_length_q != '0) begin
          busy_d = 1'b1;
          idx_d  = '0;
          acc_d  = '0;
          step_d = accel_ph;
        end
      end else begin
        acc_d  = acc_q + step_q;
        step_d = step_q + {accel_ph[PHASE_BITS-2:0], 1'b0};
        idx_d  = idx_next[LENGTH_BITS-1:0];
        if (idx_next >= {1'b0, pulse_length_q}) begin
          busy_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      acc_q  <= '0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      acc_q  <= acc_d;
      step_q <= step_d;
    end
  end

  // ---------------------------------------------------------------- stage a: address

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_a_q  <= busy_q;
      addr_a_q <= acc_q[PHASE_BITS-1 -: TA];
    end
  end

  // ---------------------------------------------------------------- stage b: sine table

  for (genvar k = 0; k <= QUARTER; k++) begin : g_rom
    assign sine_rom[k] = quarter_sine(k, TA - 2);
  end

  // cosine sits one quadrant ahead of sine
  assign quad_s    = addr_a_q[TA-1 -: 2];
  assign quad_c    = quad_s + 2'd1;
  assign frac      = addr_a_q[TA-3:0];
  assign rom_idx_s = quad_s[0] ? (QUARTER_IDX - {1'b0, frac}) : {1'b0, frac};
  assign rom_idx_c = quad_c[0] ? (QUARTER_IDX - {1'b0, frac}) : {1'b0, frac};

  always_ff @(posedge clk_i) begin
    if (rdy_b && vld_a_q) begin
      act_b_q <= act_a_q;
      mag_s_q <= sine_rom[rom_idx_s];
      neg_s_q <= quad_s[1];
      mag_c_q <= sine_rom[rom_idx_c];
      neg_c_q <= quad_c[1];
    end
  end

  // ---------------------------------------------------------------- stage c: amplitude

  // round half away from zero on the magnitude, then restore the sign
  assign rnd_s = (PROD_W + 1)'(mag_s_q) * (PROD_W + 1)'(amplitude_q)
               + (PROD_W + 1)'(16384);
  assign rnd_c = (PROD_W + 1)'(mag_c_q) * (PROD_W + 1)'(amplitude_q)
               + (PROD_W + 1)'(16384);
  assign m_s   = SAMPLE_BITS'(rnd_s[PROD_W:AMP_BITS]);
  assign m_c   = SAMPLE_BITS'(rnd_c[PROD_W:AMP_BITS]);

  always_ff @(posedge clk_i) begin
    if (rdy_c && vld_b_q) begin
      if (act_b_q) begin
        out_i_q <= neg_c_q ? signed'(-m_c) : signed'(m_c);
        out_q_q <= neg_s_q ? signed'(-m_s) : signed'(m_s);
      end else begin
        out_i_q <= '0;
        out_q_q <= '0;
      end
    end
  end

  assign out_valid_o = vld_c_q;
  assign out_i_o     = out_i_q;
  assign out_q_o     = out_q_q;

  // ---------------------------------------------------------------- assertions

  `TCG_ASSERT_NEXT(a_zero_length_stays_idle, clk_i, rst_ni,
    in_acc && !busy_q && trigger_i && pulse_length_q == '0, !busy_q)
  `TCG_ASSERT_NEXT(a_out_held_while_stalled, clk_i, rst_ni,
    out_valid_o && out_stall_i, out_valid_o && $stable(out_i_o) && $stable(out_q_o))
  `TCG_ASSERT_NEXT(a_pulse_ends_on_last, clk_i, rst_ni,
    in_acc && busy_q && (idx_next >= (LENGTH_BITS + 1)'(pulse_length_q)), !busy_q)
  `TCG_ASSERT_IMPL(a_stall_only_when_full, clk_i, rst_ni,
    in_stall_o, vld_a_q && vld_b_q && out_valid_o && out_stall_i)

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// self-checking testbench for the triggered chirp generator core

class chirp_tracker;
  localparam longint unsigned PI_FRAC_Q30 = 64'd3373259426;
  localparam longint unsigned PEAK = 64'd32767;

  logic [15:0]        pulse_len;
  logic [31:0]        accel;
  logic [14:0]        amp;
  bit                 busy;
  logic [15:0]        slot_count;
  logic [31:0]        phase;
  logic [31:0]        phase_inc;
  int                 quarter_wave[0:256];
  logic signed [15:0] due_i[$];
  logic signed [15:0] due_q[$];
  bit                 failed;

  function new();
    int k;
    for (k = 0; k <= 256; k++) begin
      quarter_wave[k] = taylor_sine(k);
    end
    pulse_len  = 16'd1024;
    accel      = '0;
    amp        = 15'h7fff;
    busy       = 1'b0;
    slot_count = '0;
    phase      = '0;
    phase_inc  = '0;
    failed     = 1'b0;
  endfunction

  // quarter-wave sine point k of 256, q30 series then scaled to full scale
  function int taylor_sine(int k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned val;
    longint          acc;
    int              n;
    x    = (PI_FRAC_Q30 * 64'(k)) / 64'd512;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (n = 1; n <= 8; n++) begin
      term = (term * x2) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    val = (64'(acc) * PEAK + (64'd1 << 29)) >> 30;
    if (val > PEAK) begin
      val = PEAK;
    end
    return int'(val);
  endfunction

  function int table_sine(logic [9:0] addr);
    case (addr[9:8])
      2'd0:    return quarter_wave[addr[7:0]];
      2'd1:    return quarter_wave[256 - addr[7:0]];
      2'd2:    return -quarter_wave[addr[7:0]];
      default: return -quarter_wave[256 - addr[7:0]];
    endcase
  endfunction

  // amplitude scaling, rounded half away from zero
  function logic [15:0] scaled(int v);
    longint unsigned mag;
    longint unsigned m;
    mag = (v < 0) ? -v : v;
    m   = (mag * 64'(amp) + 64'd16384) >> 15;
    return (v < 0) ? 16'(64'd0 - m) : 16'(m);
  endfunction

  function void write_reg(int index, logic [31:0] value);
    case (index)
      tcg_pkg::REG_PULSE_LENGTH: pulse_len = value[15:0];
      tcg_pkg::REG_CHIRP_ACCEL:  accel     = value;
      tcg_pkg::REG_AMPLITUDE:    amp       = value[14:0];
      default: ;
    endcase
  endfunction

  function void note_slot(bit trig);
    logic [9:0]  addr;
    logic [16:0] next;
    if (!busy) begin
      due_i.push_back('0);
      due_q.push_back('0);
      if (trig && pulse_len != 0) begin
        busy       = 1'b1;
        slot_count = '0;
        phase      = '0;
        phase_inc  = accel;
      end
      return;
    end
    addr = phase[31:22];
    due_i.push_back(scaled(table_sine(addr + 10'd256)));
    due_q.push_back(scaled(table_sine(addr)));
    phase     = phase + phase_inc;
    phase_inc = phase_inc + {accel[30:0], 1'b0};
    next      = {1'b0, slot_count} + 17'd1;
    // pulse ends once the count reaches the current length, even if shortened
    if (next >= {1'b0, pulse_len}) begin
      busy = 1'b0;
    end
    slot_count = next[15:0];
  endfunction

  function void check_sample(logic signed [15:0] got_i, logic signed [15:0] got_q);
    logic signed [15:0] want_i;
    logic signed [15:0] want_q;
    if (due_i.size() == 0) begin
      $error("unexpected result: out_i=%0d out_q=%0d", got_i, got_q);
      failed = 1'b1;
      return;
    end
    want_i = due_i.pop_front();
    want_q = due_q.pop_front();
    if (got_i !== want_i) begin
      $error("out_i mismatch: expected %0d, actual %0d", want_i, got_i);
      failed = 1'b1;
    end
    if (got_q !== want_q) begin
      $error("out_q mismatch: expected %0d, actual %0d", want_q, got_q);
      failed = 1'b1;
    end
  endfunction

  function int due_count();
    return due_i.size();
  endfunction
endclass

module testbench;
  import tcg_pkg::*;

  localparam logic [ADDR_BITS-1:0] SPARE_REG_ADDR = 4'd12;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic                          trigger_i;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic signed [SAMPLE_BITS-1:0] out_i_o;
  logic signed [SAMPLE_BITS-1:0] out_q_o;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [ADDR_BITS-1:0]          paddr;
  logic [DATA_BITS-1:0]          pwdata;
  logic [DATA_BITS-1:0]          prdata;
  logic                          pready;

  chirp_tracker tracker;
  int           tx_idle_pct;
  int           rx_idle_pct;

  triggered_chirp_generator_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .trigger_i  (trigger_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_i_o    (out_i_o),
    .out_q_o    (out_q_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #1 clk_i = ~clk_i;

  // result side: check each transfer, then pick next cycle's stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        tracker.check_sample(out_i_o, out_q_o);
      end
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  task automatic send_slot(bit trig);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      trigger_i  <= 1'($urandom_range(1));
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    trigger_i  <= trig;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_slot(trig);
  endtask

  task automatic apb_write(logic [ADDR_BITS-1:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    tracker.write_reg(int'(addr >> 2), data);
    @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e r, logic [31:0] data);
    apb_write({r, 2'b00}, data);
  endtask

  // let every outstanding sample leave before touching registers
  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.due_count() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    logic [15:0] len;
    logic [31:0] acc;
    logic [14:0] amp;
    int          p;
    int          n;
    tracker    = new();
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    trigger_i  = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    tx_idle_pct = 18;
    rx_idle_pct = 80;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: idle slot, trigger, retrigger while busy, chirp samples
    send_slot(1'b0);
    send_slot(1'b1);
    send_slot(1'b1);
    send_slot(1'b0);
    send_slot(1'b0);
    // shorten the pulse below the current count
    drain();
    write_reg(REG_PULSE_LENGTH, 32'h0000_0002);
    send_slot(1'b0);
    send_slot(1'b0);
    // zero length with junk upper bits: trigger is ignored
    drain();
    write_reg(REG_PULSE_LENGTH, 32'habcd_0000);
    send_slot(1'b1);
    send_slot(1'b0);
    // unknown register, then all-ones settings and phase wrap
    drain();
    apb_write(SPARE_REG_ADDR, $urandom());
    write_reg(REG_AMPLITUDE, 32'hffff_ffff);
    write_reg(REG_CHIRP_ACCEL, 32'hffff_ffff);
    write_reg(REG_PULSE_LENGTH, 32'h1234_0006);
    send_slot(1'b1);
    for (n = 0; n < 7; n++) begin
      send_slot(1'($urandom_range(1)));
    end
    // single-sample pulses back to back, zero amplitude
    drain();
    write_reg(REG_AMPLITUDE, 32'h0000_0000);
    write_reg(REG_CHIRP_ACCEL, 32'h4000_0000);
    write_reg(REG_PULSE_LENGTH, 32'h0000_0001);
    send_slot(1'b1);
    send_slot(1'b1);
    send_slot(1'b1);
    send_slot(1'b0);
    // longest pulse, left running into the random part
    drain();
    write_reg(REG_PULSE_LENGTH, 32'h0000_ffff);
    write_reg(REG_AMPLITUDE, 32'h0000_0001);
    send_slot(1'b1);
    send_slot(1'b0);
    send_slot(1'b0);

    for (p = 0; p < 10; p++) begin
      if (p < 4) begin
        tx_idle_pct = 18;
        rx_idle_pct = 80;
      end else if (p < 7) begin
        tx_idle_pct = 80;
        rx_idle_pct = 18;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case ($urandom_range(9))
        0:       len = 16'd0;
        1:       len = 16'd1;
        2:       len = 16'hffff;
        default: len = 16'($urandom_range(40, 2));
      endcase
      case ($urandom_range(3))
        0:       acc = '0;
        1:       acc = '1;
        default: acc = $urandom();
      endcase
      case ($urandom_range(4))
        0:       amp = '0;
        1:       amp = 15'h7fff;
        default: amp = 15'($urandom_range(32767));
      endcase
      drain();
      write_reg(REG_PULSE_LENGTH, ($urandom() & 32'hffff_0000) | 32'(len));
      write_reg(REG_CHIRP_ACCEL, acc);
      write_reg(REG_AMPLITUDE, ($urandom() & 32'hffff_8000) | 32'(amp));
      for (n = 0; n < 100; n++) begin
        send_slot($urandom_range(7) == 0);
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (!tracker.failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Test completed with failures");
    $finish;
  end
endmodule
